/* design/ftr_pkg.sv */
// ----------------------------------------------------------------------------
// ftr_pkg
// Shared constants and the 2^-f table for the Foster thermal response block.
// ----------------------------------------------------------------------------
package ftr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_STAGES = 3;
  localparam int ACC_W      = 52;
  localparam int RES_W      = 48;

  localparam logic [20:0] XCAP      = 21'h100000;  // 16.0 in Q.16
  localparam logic [32:0] LOG2E_Q16 = 33'd94548;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SATD = 2'd1;
  localparam logic [1:0] ST_BADI = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  localparam logic [1:0] FN_STEP_SUM = 2'd0;
  localparam logic [1:0] FN_IMP_SUM  = 2'd1;
  localparam logic [1:0] FN_STEP_ONE = 2'd2;

  localparam logic [2:0] REG_STAGES  = 3'd0;
  localparam logic [2:0] REG_AMBIENT = 3'd7;

  // 2^(-j/16) in Q.16, j = 0..16
  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] v;
    case (j)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/foster_thermal_response.sv */
// ----------------------------------------------------------------------------
// foster_thermal_response
// Step / impulse response of a Foster RC thermal network, up to three stages.
// ----------------------------------------------------------------------------
// Channel  Ports                                   Handshake
// in       in_func in_stage_index in_time_value    start && !busy
//          in_power_value
// out      out_result_value out_status             out_valid, one cycle
// cfg      cfg_index cfg_wdata                     cfg_we
//
// Per stage: a tau multiply, a t/tau divide (a load state, then one
// quotient bit per cycle), the exp steps, then the step term or 1/C and
// the impulse term; the stages run between the check and saturate states.
// Early-out cases (bad index, negative time, zero R/C) finish in the check
// state. One 33x33 multiplier is shared.
// Reset (synchronous, rst_n low) returns the FSM to idle, and out_valid and
// the configuration registers to their defaults. Results cannot be stalled;
// out_valid pulses once.
// ----------------------------------------------------------------------------
module foster_thermal_response
  import ftr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_func,
  input  logic [1:0]               in_stage_index,
  input  logic signed [31:0]       in_time_value,
  input  logic signed [31:0]       in_power_value,
  output logic                     out_valid,
  output logic signed [RES_W-1:0]  out_result_value,
  output logic [1:0]               out_status,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_TAU   = 4'd2;
  localparam logic [3:0] S_DLDX  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_EXPY  = 4'd5;
  localparam logic [3:0] S_EXPI  = 4'd6;
  localparam logic [3:0] S_EXPV  = 4'd7;
  localparam logic [3:0] S_STEP  = 4'd8;
  localparam logic [3:0] S_PWR   = 4'd9;
  localparam logic [3:0] S_DLDI  = 4'd10;
  localparam logic [3:0] S_IMP   = 4'd11;
  localparam logic [3:0] S_ADD   = 4'd12;
  localparam logic [3:0] S_SAT   = 4'd13;

  // configuration
  logic [1:0]  stages_r;
  logic [31:0] res_r [MAX_STAGES];
  logic [31:0] cap_r [MAX_STAGES];
  logic [31:0] amb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stages_r <= 2'd3;
      for (int i = 0; i < MAX_STAGES; i++) begin
        res_r[i] <= 32'h10000;
        cap_r[i] <= 32'h10000;
      end
      amb_r <= 32'd25 << FRAC_BITS;
    end else if (cfg_we) begin
      if (cfg_index == REG_STAGES) begin
        stages_r <= cfg_wdata[1:0];
      end else if (cfg_index == REG_AMBIENT) begin
        amb_r <= cfg_wdata;
      end else if (cfg_index[0]) begin
        res_r[2'((cfg_index - 3'd1) >> 1)] <= cfg_wdata;
      end else begin
        cap_r[2'((cfg_index - 3'd1) >> 1)] <= cfg_wdata;
      end
    end
  end

  // datapath registers
  logic [3:0]              state_r, state_nxt;
  logic [1:0]              func_r, func_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic signed [31:0]      t_r, t_nxt;
  logic signed [31:0]      p_r, p_nxt;
  logic [1:0]              s_r, s_nxt;
  logic [1:0]              last_r, last_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [65:0]             prod_r, prod_nxt;
  logic [63:0]             num_r, num_nxt;
  logic [63:0]             den_r, den_nxt;
  logic [63:0]             rem_r, rem_nxt;
  logic [63:0]             q_r, q_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  logic                    kind_r, kind_nxt;   // 1: divide for 1/C
  logic [4:0]              k_r, k_nxt;
  logic [3:0]              j_r, j_nxt;
  logic [16:0]             e_r, e_nxt;
  logic                    ov_r, ov_nxt;
  logic signed [RES_W-1:0] ores_r, ores_nxt;
  logic [1:0]              osta_r, osta_nxt;

  // shared multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [31:0] cur_r, cur_c;
  assign cur_r = res_r[s_r];
  assign cur_c = cap_r[s_r];

  logic [32:0] p_mag;
  assign p_mag = p_r[31] ? 33'(-{p_r[31], p_r}) : {1'b0, p_r};

  logic [20:0] x_cap;
  assign x_cap = (q_r > 64'(XCAP)) ? XCAP : q_r[20:0];

  // divider step
  logic [64:0] rem_sh;
  logic        div_ge;
  assign rem_sh = {rem_r, num_r[63]};
  assign div_ge = rem_sh >= {1'b0, den_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TAU:  begin mul_a = {1'b0, cur_r}; mul_b = {1'b0, cur_c}; end
      S_EXPY: begin mul_a = 33'(x_cap); mul_b = LOG2E_Q16; end
      S_EXPI: begin
        mul_a = 33'(pow2_tab({1'b0, prod_r[31:28]})
                    - pow2_tab(5'({1'b0, prod_r[31:28]} + 5'd1)));
        mul_b = 33'(prod_r[27:16]);
      end
      S_STEP: begin mul_a = {1'b0, cur_r}; mul_b = 33'(ONE_Q16 - e_r); end
      S_PWR:  begin mul_a = p_mag; mul_b = prod_r[48:16]; end
      S_IMP:  begin mul_a = q_r[32:0]; mul_b = 33'(e_r); end
      default: ;
    endcase
  end

  logic        bad_zero;
  logic [1:0]  first_s;
  logic [16:0] v_int;
  logic [49:0] term;

  always_comb begin
    state_nxt = state_r; func_nxt = func_r; idx_nxt = idx_r;
    t_nxt = t_r; p_nxt = p_r; s_nxt = s_r; last_nxt = last_r;
    acc_nxt = acc_r; prod_nxt = prod_r; num_nxt = num_r; den_nxt = den_r;
    rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r; kind_nxt = kind_r;
    k_nxt = k_r; j_nxt = j_r; e_nxt = e_r;
    ov_nxt = 1'b0; ores_nxt = ores_r; osta_nxt = osta_r;
    bad_zero = 1'b0;
    first_s  = (func_r[1]) ? idx_r : 2'd0;
    v_int    = '0;
    term     = prod_r[65:16];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt = in_func; idx_nxt = in_stage_index;
          t_nxt = in_time_value; p_nxt = in_power_value;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        for (int i = 0; i < MAX_STAGES; i++) begin
          if ((func_r[1] ? (idx_r == 2'(i)) : (2'(i) < stages_r))
              && (res_r[i] == '0 || cap_r[i] == '0))
            bad_zero = 1'b1;
        end
        acc_nxt  = (func_r == FN_STEP_SUM) ? ACC_W'(signed'(amb_r)) : '0;
        s_nxt    = first_s;
        last_nxt = func_r[1] ? 2'(idx_r + 2'd1) : stages_r;
        if (func_r[1] && idx_r >= stages_r) begin
          ores_nxt = '0; osta_nxt = ST_BADI; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else if (t_r[31]) begin
          ores_nxt = (func_r == FN_STEP_SUM) ? RES_W'(signed'(amb_r)) : '0;
          osta_nxt = ST_OK; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else if (bad_zero) begin
          ores_nxt = '0; osta_nxt = ST_ZERO; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else if (!func_r[1] && stages_r == 2'd0) begin
          state_nxt = S_SAT;
        end else begin
          state_nxt = S_TAU;
        end
      end
      S_TAU: begin
        prod_nxt  = mul_p;
        state_nxt = S_DLDX;
      end
      S_DLDX: begin
        num_nxt = {t_r, 32'd0}; den_nxt = prod_r[63:0];
        rem_nxt = '0; q_nxt = '0; cnt_nxt = '0; kind_nxt = 1'b0;
        state_nxt = S_DIV;
      end
      S_DLDI: begin
        num_nxt = 64'h1_0000_0000; den_nxt = {32'd0, cur_c};
        rem_nxt = '0; q_nxt = '0; cnt_nxt = '0; kind_nxt = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = div_ge ? 64'(rem_sh - {1'b0, den_r}) : rem_sh[63:0];
        q_nxt   = {q_r[62:0], div_ge};
        num_nxt = {num_r[62:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = kind_r ? S_IMP : S_EXPY;
      end
      S_EXPY: begin
        prod_nxt  = mul_p;
        state_nxt = S_EXPI;
      end
      S_EXPI: begin
        // y = prod >> 16: k integer part, j/lo interpolation position
        k_nxt = prod_r[36:32];
        j_nxt = prod_r[31:28];
        prod_nxt  = mul_p;
        state_nxt = S_EXPV;
      end
      S_EXPV: begin
        v_int = pow2_tab({1'b0, j_r}) - 17'(prod_r[65:12]);
        e_nxt = (k_r > 5'd16) ? '0 : (v_int >> k_r);
        state_nxt = func_r[0] ? S_DLDI : S_STEP;
      end
      S_STEP: begin
        prod_nxt  = mul_p;
        state_nxt = (func_r == FN_STEP_ONE) ? S_ADD : S_PWR;
      end
      S_PWR: begin
        prod_nxt  = mul_p;
        state_nxt = S_ADD;
      end
      S_IMP: begin
        prod_nxt  = mul_p;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (func_r == FN_STEP_SUM && p_r[31])
          acc_nxt = acc_r - signed'({2'b00, term});
        else
          acc_nxt = acc_r + signed'({2'b00, term});
        s_nxt = s_r + 2'd1;
        state_nxt = ({1'b0, s_r} + 3'd1 == {1'b0, last_r}) ? S_SAT : S_TAU;
      end
      S_SAT: begin
        if (acc_r > ACC_W'(signed'({1'b0, {(RES_W-1){1'b1}}}))) begin
          ores_nxt = {1'b0, {(RES_W-1){1'b1}}}; osta_nxt = ST_SATD;
        end else if (acc_r < ACC_W'(signed'({1'b1, {(RES_W-1){1'b0}}}))) begin
          ores_nxt = {1'b1, {(RES_W-1){1'b0}}}; osta_nxt = ST_SATD;
        end else begin
          ores_nxt = acc_r[RES_W-1:0]; osta_nxt = ST_OK;
        end
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    func_r <= func_nxt; idx_r <= idx_nxt; t_r <= t_nxt; p_r <= p_nxt;
    s_r <= s_nxt; last_r <= last_nxt; acc_r <= acc_nxt; prod_r <= prod_nxt;
    num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
    cnt_r <= cnt_nxt; kind_r <= kind_nxt; k_r <= k_nxt; j_r <= j_nxt;
    e_r <= e_nxt; ores_r <= ores_nxt; osta_r <= osta_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_result_value = ores_r;
  assign out_status       = osta_r;

`ifndef SYNTH
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("item not taken");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BADI || out_status == ST_ZERO)
    |-> out_result_value == '0) else $error("error result not zero");
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
`endif

endmodule
